@@ rtl/mhpq_pkg.sv @@
// mhpq_pkg: shared types, codes and default sizes for the max-heap queue.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mhpq_pkg;

  // fixed field widths of the request and response channels
  localparam int VALUE_W  = 32;
  localparam int RESULT_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // default sizing of the store
  localparam int DEF_HEAP_DEPTH = 256;
  localparam int DEF_KEY_WIDTH  = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_RM_RD,
    ST_RM_LD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [RESULT_W-1:0] result_value;
    status_t             status;
    logic [COUNT_W-1:0]  count_after;
  } rslt_t;

endpackage

@@ rtl/mhpq_req_if.sv @@
// mhpq_req_if: request channel (command and key) with valid/ready.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps

interface mhpq_req_if import mhpq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

@@ rtl/mhpq_rsp_if.sv @@
// mhpq_rsp_if: response channel (removed key, status, count) with valid/ready.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps

interface mhpq_rsp_if import mhpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count_after;

  modport source (output valid, output result_value, output status, output count_after,
                  input ready);
  modport sink   (input valid, input result_value, input status, input count_after,
                  output ready);
endinterface

@@ rtl/mhpq_ram.sv @@
// mhpq_ram: generic RAM, one write port, two read ports, registered reads.
// Depends on mhpq_pkg for its default sizes.
`timescale 1ns / 1ps

module mhpq_ram import mhpq_pkg::*; #(
  parameter int WIDTH = DEF_KEY_WIDTH,
  parameter int DEPTH = DEF_HEAP_DEPTH,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [WIDTH-1:0]  rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/mhpq_ctrl.sv @@
// mhpq_ctrl: sequencer for insert (sift up) and remove (sift down).
// Depends on mhpq_pkg, mhpq_req_if; drives the ports of mhpq_ram.
`timescale 1ns / 1ps

module mhpq_ctrl import mhpq_pkg::*; #(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
  parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
  localparam int IDX_W = $clog2(HEAP_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mhpq_req_if.sink             req,
  // store
  output logic                 ram_we,
  output logic [IDX_W-1:0]     ram_waddr,
  output logic [KEY_WIDTH-1:0] ram_wdata,
  output logic [IDX_W-1:0]     ram_raddr_a,
  input  logic [KEY_WIDTH-1:0] ram_rdata_a,
  output logic [IDX_W-1:0]     ram_raddr_b,
  input  logic [KEY_WIDTH-1:0] ram_rdata_b,
  // finished result towards the output stage
  output logic                 rslt_valid,
  output rslt_t                rslt,
  input  logic                 rslt_ready
);

  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int EXT_W = IDX_W + 2;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;        // element being sifted
  logic [KEY_WIDTH-1:0] res_value_r, res_value_nxt;
  status_t              status_r, status_nxt;

  logic             accept;
  logic             is_full, is_empty;
  logic [EXT_W-1:0] pos_ext, left_ext, right_ext, cnt_ext;
  logic             has_left, has_right;
  logic [IDX_W-1:0] parent_idx, left_idx, right_idx;
  logic             up_swap, dn_stop, dn_pick_r;

  // requests are taken only while idle
  assign req.ready = (state_r == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_full   = (cnt_r == CNT_W'(HEAP_DEPTH));
  assign is_empty  = (cnt_r == '0);

  assign pos_ext    = EXT_W'(pos_r);
  assign left_ext   = (pos_ext << 1) + EXT_W'(1);
  assign right_ext  = left_ext + EXT_W'(1);
  assign cnt_ext    = EXT_W'(cnt_r);
  assign has_left   = (left_ext < cnt_ext);
  assign has_right  = (right_ext < cnt_ext);
  assign left_idx   = left_ext[IDX_W-1:0];
  assign right_idx  = right_ext[IDX_W-1:0];
  assign parent_idx = (pos_r - IDX_W'(1)) >> 1;

  // sift up: parent read back in ram_rdata_a
  assign up_swap = (key_r > ram_rdata_a);

  // sift down: left child on port a, right child on port b
  always_comb begin
    if (has_right) begin
      dn_stop   = (key_r > ram_rdata_a) && (key_r > ram_rdata_b);
      dn_pick_r = (ram_rdata_b > ram_rdata_a);
    end else begin
      dn_stop   = (key_r > ram_rdata_a);
      dn_pick_r = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (req.command == CMD_REMOVE) begin
            state_nxt = is_empty ? ST_FIN : ST_RM_RD;
          end else begin
            state_nxt = is_full ? ST_FIN : ST_UP_RD;
          end
        end
      end
      ST_UP_RD:  state_nxt = (pos_r == '0) ? ST_FIN : ST_UP_CMP;
      ST_UP_CMP: state_nxt = up_swap ? ST_UP_RD : ST_FIN;
      ST_RM_RD:  state_nxt = ST_RM_LD;
      ST_RM_LD:  state_nxt = (cnt_r == '0) ? ST_FIN : ST_DN_RD;
      ST_DN_RD:  state_nxt = has_left ? ST_DN_CMP : ST_FIN;
      ST_DN_CMP: state_nxt = dn_stop ? ST_FIN : ST_DN_RD;
      ST_FIN:    state_nxt = rslt_ready ? ST_IDLE : ST_FIN;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    res_value_nxt = res_value_r;
    status_nxt    = status_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = key_r;
    ram_raddr_a   = parent_idx;
    ram_raddr_b   = right_idx;
    rslt_valid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_value_nxt = '0;
          status_nxt    = STATUS_OK;
          if (req.command == CMD_REMOVE) begin
            if (is_empty) begin
              status_nxt = STATUS_EMPTY;
            end else begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end else begin
            if (is_full) begin
              status_nxt = STATUS_FULL;
            end else begin
              pos_nxt = cnt_r[IDX_W-1:0];
              key_nxt = KEY_WIDTH'(req.value);
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
        end
      end
      ST_UP_RD: begin
        if (pos_r == '0) begin
          ram_we = 1'b1;
        end
      end
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (up_swap) begin
          ram_wdata = ram_rdata_a;     // parent moves down
          pos_nxt   = parent_idx;
        end
      end
      ST_RM_RD: begin
        ram_raddr_a = '0;
        ram_raddr_b = cnt_r[IDX_W-1:0];  // last element, count already decremented
      end
      ST_RM_LD: begin
        res_value_nxt = ram_rdata_a;
        key_nxt       = ram_rdata_b;
        pos_nxt       = '0;
      end
      ST_DN_RD: begin
        ram_raddr_a = left_idx;
        if (!has_left) begin
          ram_we = 1'b1;
        end
      end
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (!dn_stop) begin
          if (dn_pick_r) begin
            ram_wdata = ram_rdata_b;
            pos_nxt   = right_idx;
          end else begin
            ram_wdata = ram_rdata_a;
            pos_nxt   = left_idx;
          end
        end
      end
      ST_FIN: begin
        rslt_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign rslt.result_value = RESULT_W'(res_value_r);
  assign rslt.status       = status_r;
  assign rslt.count_after  = COUNT_W'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    key_r       <= key_nxt;
    res_value_r <= res_value_nxt;
    status_r    <= status_nxt;
  end

endmodule

@@ rtl/mhpq_out_stage.sv @@
// mhpq_out_stage: response register, frees the sequencer while a result waits.
// Depends on mhpq_pkg, mhpq_rsp_if.
`timescale 1ns / 1ps

module mhpq_out_stage import mhpq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rslt_valid,
  input  rslt_t       rslt,
  output logic        rslt_ready,
  mhpq_rsp_if.source  rsp
);

  logic  out_valid_r;
  rslt_t data_r;
  logic  load;

  assign rslt_ready = !out_valid_r || rsp.ready;
  assign load       = rslt_valid && rslt_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= rslt;
    end
  end

  assign rsp.valid        = out_valid_r;
  assign rsp.result_value = data_r.result_value;
  assign rsp.status       = data_r.status;
  assign rsp.count_after  = data_r.count_after;

endmodule

@@ rtl/max_heap_priority_queue.sv @@
// Binary max-heap priority queue: top level.
// Request channel in_req (sink): command (0 insert key, 1 remove maximum) and
// value (the key, taken in its low KEY_WIDTH bits). A request is taken when
// valid and ready are both high; ready is high only while the sequencer is idle.
// Response channel out_rsp (source): one response per request carrying the
// removed key (zero on insert or error), status (ok, remove from empty, insert
// into full) and the element count after the operation.
// Each insert or remove walks the heap one level at a time in a read-compare-write
// loop over the store memory (registered read, then compare and write back);
// a rejected request goes straight to the response. The response is offered
// in the same cycle that ready rises again; one request in work at a time.
// Reset (rst_n, synchronous, active low) empties the heap by clearing the
// count; the store itself needs no clearing pass since only entries below the
// count are ever read. If the receiver stalls, the response register holds its
// contents, the sequencer may take and finish one more request and hold its
// result, and after that no request is taken.
// Depends on mhpq_pkg, mhpq_req_if, mhpq_rsp_if, mhpq_ram, mhpq_ctrl,
// mhpq_out_stage.
`timescale 1ns / 1ps

module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
  parameter int KEY_WIDTH  = DEF_KEY_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  mhpq_req_if.sink    in_req,
  mhpq_rsp_if.source  out_rsp
);

  localparam int IDX_W = $clog2(HEAP_DEPTH);

  // store port wiring
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr_a;
  logic [KEY_WIDTH-1:0] ram_rdata_a;
  logic [IDX_W-1:0]     ram_raddr_b;
  logic [KEY_WIDTH-1:0] ram_rdata_b;

  // sequencer to response register
  logic  rslt_valid;
  logic  rslt_ready;
  rslt_t rslt;

  // sift engine: root is entry 0, children of i at 2i+1 and 2i+2
  mhpq_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_req),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_rdata_a (ram_rdata_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_b (ram_rdata_b),
    .rslt_valid  (rslt_valid),
    .rslt        (rslt),
    .rslt_ready  (rslt_ready)
  );

  // key store; port b used for the right child and the last element
  mhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (HEAP_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  mhpq_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .rslt_valid (rslt_valid),
    .rslt       (rslt),
    .rslt_ready (rslt_ready),
    .rsp        (out_rsp)
  );

endmodule
